// ===== src/vctk_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// vctk_pkg
// Shared types and constants for the view cone cull and top-k select core.
// ============================================================================
package vctk_pkg;

    localparam int MAX_CAND  = 64;
    localparam int ADDR_W    = 6;
    localparam int CNT_W     = 7;
    localparam int ENTRY_W   = 44;

    // level of detail thresholds (Q4.12)
    localparam logic [15:0] COV_FULL_TH = 16'd1433;
    localparam logic [15:0] IMP_FULL_TH = 16'd3276;
    localparam logic [15:0] COV_MID_TH  = 16'd327;

    localparam logic [1:0] LVL_FULL   = 2'd0;
    localparam logic [1:0] LVL_MID    = 2'd1;
    localparam logic [1:0] LVL_COARSE = 2'd2;

    // iteration ends
    localparam logic [5:0] AXIS_LAST = 6'd2;
    localparam logic [5:0] ROOT_LAST = 6'd25;
    localparam logic [5:0] DIV_LAST  = 6'd17;

    typedef enum logic [2:0] {
        CFG_VIEWER_X  = 3'd0,
        CFG_VIEWER_Y  = 3'd1,
        CFG_VIEWER_Z  = 3'd2,
        CFG_VIEW_DIR  = 3'd3,
        CFG_CONE_COS  = 3'd4,
        CFG_NEAR      = 3'd5,
        CFG_FAR       = 3'd6,
        CFG_BUDGET    = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_RINIT,
        ST_ROOT,
        ST_NEAR,
        ST_DOT,
        ST_DINIT,
        ST_DIV,
        ST_CONE,
        ST_INS_RD,
        ST_INS,
        ST_FIN,
        ST_EM_RD,
        ST_EM_LD,
        ST_EM_WAIT
    } t_state;

    typedef struct packed {
        logic load;
        logic mul_sq;
        logic mul_dot;
        logic step_clr;
        logic step_inc;
        logic root_init;
        logic root_step;
        logic div_init;
        logic div_step;
        logic rej_inc;
        logic score_ld;
        logic ins_start;
        logic ins_step;
        logic fin_ld;
        logic em_rd;
        logic em_ld;
        logic set_clr;
    } t_cmd;

    typedef struct packed {
        logic axis_last;
        logic root_last;
        logic div_last;
        logic cull_near;
        logic cull_cone;
        logic store_full;
        logic ins_hit;
        logic end_flag;
        logic emit_empty;
        logic emit_last;
        logic out_taken;
    } t_stat;

endpackage

// ===== src/vctk_cand_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// vctk_cand_if
// Candidate word channel: valid, ready and the candidate fields.
// ============================================================================
interface vctk_cand_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] obj_x;
    logic signed [23:0] obj_y;
    logic signed [23:0] obj_z;
    logic [23:0]        bound_radius;
    logic [15:0]        importance;
    logic [15:0]        coverage;
    logic               full_detail;
    logic [15:0]        object_id;
    logic               set_end;

    modport source (output valid, obj_x, obj_y, obj_z, bound_radius, importance,
                    coverage, full_detail, object_id, set_end, input ready);
    modport sink   (input valid, obj_x, obj_y, obj_z, bound_radius, importance,
                    coverage, full_detail, object_id, set_end, output ready);
endinterface

// ===== src/vctk_res_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// vctk_res_if
// Result word channel: valid, ready and the result fields.
// ============================================================================
interface vctk_res_if;
    logic               valid;
    logic               ready;
    logic [15:0]        out_id;
    logic [1:0]         detail_level;
    logic signed [25:0] rank_score;
    logic [15:0]        rejected_total;
    logic               none_visible;
    logic               run_end;

    modport source (output valid, out_id, detail_level, rank_score, rejected_total,
                    none_visible, run_end, input ready);
    modport sink   (input valid, out_id, detail_level, rank_score, rejected_total,
                    none_visible, run_end, output ready);
endinterface

// ===== src/vctk_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// vctk_ctrl
// Sequencer: steps one candidate through the datapath, then drains a set.
// ============================================================================
module vctk_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  vctk_pkg::t_stat i_stat,
    output vctk_pkg::t_cmd  o_cmd
);

    vctk_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vctk_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            vctk_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.step_clr = 1'b1;
                    n_state        = vctk_pkg::ST_SQ;
                end
            end
            vctk_pkg::ST_SQ: begin
                o_cmd.mul_sq   = 1'b1;
                o_cmd.step_inc = 1'b1;
                if (i_stat.axis_last) n_state = vctk_pkg::ST_RINIT;
            end
            vctk_pkg::ST_RINIT: begin
                o_cmd.root_init = 1'b1;
                o_cmd.step_clr  = 1'b1;
                n_state         = vctk_pkg::ST_ROOT;
            end
            vctk_pkg::ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                o_cmd.step_inc  = 1'b1;
                if (i_stat.root_last) n_state = vctk_pkg::ST_NEAR;
            end
            vctk_pkg::ST_NEAR: begin
                if (i_stat.cull_near) begin
                    o_cmd.rej_inc = 1'b1;
                    n_state       = vctk_pkg::ST_FIN;
                end else begin
                    o_cmd.step_clr = 1'b1;
                    n_state        = vctk_pkg::ST_DOT;
                end
            end
            vctk_pkg::ST_DOT: begin
                o_cmd.mul_dot  = 1'b1;
                o_cmd.step_inc = 1'b1;
                if (i_stat.axis_last) n_state = vctk_pkg::ST_DINIT;
            end
            vctk_pkg::ST_DINIT: begin
                o_cmd.div_init = 1'b1;
                o_cmd.step_clr = 1'b1;
                n_state        = vctk_pkg::ST_DIV;
            end
            vctk_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                o_cmd.step_inc = 1'b1;
                if (i_stat.div_last) n_state = vctk_pkg::ST_CONE;
            end
            vctk_pkg::ST_CONE: begin
                if (i_stat.cull_cone || i_stat.store_full) begin
                    o_cmd.rej_inc = 1'b1;
                    n_state       = vctk_pkg::ST_FIN;
                end else begin
                    o_cmd.score_ld = 1'b1;
                    n_state        = vctk_pkg::ST_INS_RD;
                end
            end
            vctk_pkg::ST_INS_RD: begin
                o_cmd.ins_start = 1'b1;
                n_state         = vctk_pkg::ST_INS;
            end
            vctk_pkg::ST_INS: begin
                o_cmd.ins_step = 1'b1;
                if (i_stat.ins_hit) n_state = vctk_pkg::ST_FIN;
            end
            vctk_pkg::ST_FIN: begin
                if (i_stat.end_flag) begin
                    o_cmd.fin_ld   = 1'b1;
                    o_cmd.step_clr = 1'b1;
                    n_state = i_stat.emit_empty ? vctk_pkg::ST_EM_LD : vctk_pkg::ST_EM_RD;
                end else begin
                    n_state = vctk_pkg::ST_IDLE;
                end
            end
            vctk_pkg::ST_EM_RD: begin
                o_cmd.em_rd = 1'b1;
                n_state     = vctk_pkg::ST_EM_LD;
            end
            vctk_pkg::ST_EM_LD: begin
                o_cmd.em_ld = 1'b1;
                n_state     = vctk_pkg::ST_EM_WAIT;
            end
            vctk_pkg::ST_EM_WAIT: begin
                if (i_stat.out_taken) begin
                    if (i_stat.emit_last) begin
                        o_cmd.set_clr = 1'b1;
                        n_state       = vctk_pkg::ST_IDLE;
                    end else begin
                        o_cmd.step_inc = 1'b1;
                        n_state        = vctk_pkg::ST_EM_RD;
                    end
                end
            end
            default: begin
                n_state = vctk_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/vctk_dp.sv =====
`timescale 1ns / 1ps
// ============================================================================
// vctk_dp
// Datapath: config registers, shared multiplier, root and divide units,
// sorted kept store and result register.
// ============================================================================
module vctk_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [47:0]        i_cfg_data,
    input  logic signed [23:0] i_obj_x,
    input  logic signed [23:0] i_obj_y,
    input  logic signed [23:0] i_obj_z,
    input  logic [23:0]        i_bound_radius,
    input  logic [15:0]        i_importance,
    input  logic [15:0]        i_coverage,
    input  logic               i_full_detail,
    input  logic [15:0]        i_object_id,
    input  logic               i_set_end,
    input  vctk_pkg::t_cmd     i_cmd,
    output vctk_pkg::t_stat    o_stat,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [15:0]        o_out_id,
    output logic [1:0]         o_detail_level,
    output logic signed [25:0] o_rank_score,
    output logic [15:0]        o_rejected_total,
    output logic               o_none_visible,
    output logic               o_run_end
);

    localparam logic [51:0] ROOT_BIT0 = 52'h4_0000_0000_0000;

    // configuration
    logic signed [23:0] r_vx, r_vy, r_vz;
    logic [47:0]        r_dir;
    logic signed [15:0] r_cone;
    logic [23:0]        r_near, r_far;
    logic [6:0]         r_budget;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vx     <= '0;
            r_vy     <= '0;
            r_vz     <= '0;
            r_dir    <= 48'h4000_0000_0000;
            r_cone   <= 16'sd14189;
            r_near   <= 24'd26;
            r_far    <= 24'hFF_FFFF;
            r_budget <= 7'd64;
        end else if (i_cfg_we) begin
            case (vctk_pkg::t_cfg_idx'(i_cfg_idx))
                vctk_pkg::CFG_VIEWER_X: r_vx     <= i_cfg_data[23:0];
                vctk_pkg::CFG_VIEWER_Y: r_vy     <= i_cfg_data[23:0];
                vctk_pkg::CFG_VIEWER_Z: r_vz     <= i_cfg_data[23:0];
                vctk_pkg::CFG_VIEW_DIR: r_dir    <= i_cfg_data;
                vctk_pkg::CFG_CONE_COS: r_cone   <= i_cfg_data[15:0];
                vctk_pkg::CFG_NEAR:     r_near   <= i_cfg_data[23:0];
                vctk_pkg::CFG_FAR:      r_far    <= i_cfg_data[23:0];
                vctk_pkg::CFG_BUDGET:   r_budget <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // candidate and work registers
    logic signed [24:0] r_dx, r_dy, r_dz;
    logic [23:0]        r_rad;
    logic [15:0]        r_imp, r_cov, r_id;
    logic               r_force, r_end;
    logic [51:0]        r_acc, r_x, r_rt, r_bit;
    logic signed [43:0] r_dot;
    logic [43:0]        r_rem;
    logic [17:0]        r_q;
    logic               r_neg;
    logic signed [25:0] r_score;
    logic [1:0]         r_lvl;
    logic [6:0]         r_cnt;
    logic [15:0]        r_total;
    logic               r_empty;
    logic [43:0]        r_rd;

    // control registers
    logic [5:0]  r_step;
    logic [6:0]  r_kept, r_k;
    logic [15:0] r_rej;
    logic        r_ovalid;

    // output payload
    logic [15:0]        r_oid;
    logic [1:0]         r_olvl;
    logic signed [25:0] r_oscore;
    logic [15:0]        r_ototal;
    logic               r_onone, r_olast;

    // shared multiplier
    logic signed [24:0] w_mul_a, w_mul_b, w_dir_c;
    logic signed [49:0] w_prod;

    always_comb begin
        case (r_step[1:0])
            2'd0:    begin w_mul_a = r_dx; w_dir_c = 25'($signed(r_dir[15:0]));  end
            2'd1:    begin w_mul_a = r_dy; w_dir_c = 25'($signed(r_dir[31:16])); end
            default: begin w_mul_a = r_dz; w_dir_c = 25'($signed(r_dir[47:32])); end
        endcase
        w_mul_b = i_cmd.mul_sq ? w_mul_a : w_dir_c;
    end

    assign w_prod = 50'(w_mul_a) * 50'(w_mul_b);

    // root step
    logic [51:0] w_rt_sum;
    logic        w_rt_ge;
    logic [25:0] w_dist;

    assign w_rt_sum = r_rt + r_bit;
    assign w_rt_ge  = r_x >= w_rt_sum;
    assign w_dist   = r_rt[25:0];

    // near / far / zero cull
    logic signed [27:0] w_back;
    assign w_back = $signed({2'b0, w_dist}) - $signed({4'b0, r_rad});

    // divide step, quotient MSB first
    logic [4:0]  w_sh;
    logic [43:0] w_den;
    logic        w_div_ge;

    assign w_sh     = 5'd17 - r_step[4:0];
    assign w_den    = {18'b0, w_dist} << w_sh;
    assign w_div_ge = r_rem >= w_den;

    // facing, score and level
    logic signed [18:0] w_fac;
    logic [31:0]        w_d41;
    logic signed [26:0] w_score;
    logic [1:0]         w_lvl;

    assign w_fac   = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
    assign w_d41   = 32'(w_dist) * 32'd41;
    assign w_score = $signed({10'b0, r_imp, 1'b0}) + $signed({9'b0, r_cov, 2'b0})
                   + 27'(w_fac >>> 2) - $signed({3'b0, w_d41[31:8]});

    always_comb begin
        if (r_force || r_cov > vctk_pkg::COV_FULL_TH || r_imp > vctk_pkg::IMP_FULL_TH) begin
            w_lvl = vctk_pkg::LVL_FULL;
        end else if (r_cov > vctk_pkg::COV_MID_TH) begin
            w_lvl = vctk_pkg::LVL_MID;
        end else begin
            w_lvl = vctk_pkg::LVL_COARSE;
        end
    end

    // set end: count and total
    logic [6:0]  w_bud, w_cnt, w_over;
    logic [16:0] w_sum;

    assign w_bud  = (r_budget > 7'(vctk_pkg::MAX_CAND)) ? 7'(vctk_pkg::MAX_CAND) : r_budget;
    assign w_cnt  = (r_kept < w_bud) ? r_kept : w_bud;
    assign w_over = r_kept - w_cnt;
    assign w_sum  = {1'b0, r_rej} + 17'(w_over);

    // store ports
    logic                              w_hit;
    logic                              w_we, w_re;
    logic [vctk_pkg::ADDR_W-1:0]       w_wa, w_ra;
    logic [vctk_pkg::ENTRY_W-1:0]      w_wd;
    logic [6:0]                        w_kept_m1, w_k_m2;
    logic [vctk_pkg::ENTRY_W-1:0]      r_mem [0:vctk_pkg::MAX_CAND-1];

    assign w_hit     = (r_k == 7'd0) || ($signed(r_rd[25:0]) >= r_score);
    assign w_kept_m1 = r_kept - 7'd1;
    assign w_k_m2    = r_k - 7'd2;

    always_comb begin
        w_we = i_cmd.ins_step;
        w_wa = r_k[vctk_pkg::ADDR_W-1:0];
        w_wd = w_hit ? {r_id, r_lvl, r_score} : r_rd;
        w_re = i_cmd.ins_start | i_cmd.ins_step | i_cmd.em_rd;
        if (i_cmd.ins_start) begin
            w_ra = w_kept_m1[vctk_pkg::ADDR_W-1:0];
        end else if (i_cmd.ins_step) begin
            w_ra = w_k_m2[vctk_pkg::ADDR_W-1:0];
        end else begin
            w_ra = r_step[vctk_pkg::ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
        if (w_re) r_rd <= r_mem[w_ra];
    end

    // payload datapath
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dx    <= 25'(i_obj_x) - 25'(r_vx);
            r_dy    <= 25'(i_obj_y) - 25'(r_vy);
            r_dz    <= 25'(i_obj_z) - 25'(r_vz);
            r_rad   <= i_bound_radius;
            r_imp   <= i_importance;
            r_cov   <= i_coverage;
            r_force <= i_full_detail;
            r_id    <= i_object_id;
            r_end   <= i_set_end;
            r_acc   <= '0;
            r_dot   <= '0;
        end
        if (i_cmd.mul_sq)  r_acc <= r_acc + 52'($unsigned(w_prod));
        if (i_cmd.mul_dot) r_dot <= r_dot + 44'(w_prod);
        if (i_cmd.root_init) begin
            r_x   <= r_acc;
            r_rt  <= '0;
            r_bit <= ROOT_BIT0;
        end
        if (i_cmd.root_step) begin
            if (w_rt_ge) begin
                r_x  <= r_x - w_rt_sum;
                r_rt <= (r_rt >> 1) + r_bit;
            end else begin
                r_rt <= r_rt >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.div_init) begin
            r_neg <= r_dot[43];
            r_rem <= r_dot[43] ? 44'(-r_dot) : 44'(r_dot);
            r_q   <= '0;
        end
        if (i_cmd.div_step) begin
            if (w_div_ge) r_rem <= r_rem - w_den;
            r_q <= {r_q[16:0], w_div_ge};
        end
        if (i_cmd.score_ld) begin
            r_score <= w_score[25:0];
            r_lvl   <= w_lvl;
        end
        if (i_cmd.fin_ld) begin
            r_cnt   <= w_cnt;
            r_total <= w_sum[16] ? 16'hFFFF : w_sum[15:0];
            r_empty <= (w_cnt == 7'd0);
        end
        if (i_cmd.em_ld) begin
            r_oid    <= r_empty ? 16'd0 : r_rd[43:28];
            r_olvl   <= r_empty ? 2'd0 : r_rd[27:26];
            r_oscore <= r_empty ? 26'sd0 : $signed(r_rd[25:0]);
            r_ototal <= r_total;
            r_onone  <= r_empty;
            r_olast  <= r_empty || (({1'b0, r_step} + 7'd1) == r_cnt);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= '0;
            r_kept   <= '0;
            r_k      <= '0;
            r_rej    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.step_clr) begin
                r_step <= '0;
            end else if (i_cmd.step_inc) begin
                r_step <= r_step + 6'd1;
            end
            if (i_cmd.ins_start) begin
                r_k <= r_kept;
            end else if (i_cmd.ins_step && !w_hit) begin
                r_k <= r_k - 7'd1;
            end
            if (i_cmd.set_clr) begin
                r_kept <= '0;
                r_rej  <= '0;
            end else begin
                if (i_cmd.ins_step && w_hit) r_kept <= r_kept + 7'd1;
                if (i_cmd.rej_inc && r_rej != 16'hFFFF) r_rej <= r_rej + 16'd1;
            end
            if (i_cmd.em_ld) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // status
    always_comb begin
        o_stat.axis_last  = (r_step == vctk_pkg::AXIS_LAST);
        o_stat.root_last  = (r_step == vctk_pkg::ROOT_LAST);
        o_stat.div_last   = (r_step == vctk_pkg::DIV_LAST);
        o_stat.cull_near  = (w_dist < {2'b0, r_near}) || (w_back > $signed({4'b0, r_far}))
                          || (w_dist == 26'd0);
        o_stat.cull_cone  = (w_fac < 19'(r_cone)) && !r_force;
        o_stat.store_full = (r_kept >= 7'(vctk_pkg::MAX_CAND));
        o_stat.ins_hit    = w_hit;
        o_stat.end_flag   = r_end;
        o_stat.emit_empty = (w_cnt == 7'd0);
        o_stat.emit_last  = r_olast;
        o_stat.out_taken  = r_ovalid && i_out_ready;
    end

    assign o_out_valid      = r_ovalid;
    assign o_out_id         = r_oid;
    assign o_detail_level   = r_olvl;
    assign o_rank_score     = r_oscore;
    assign o_rejected_total = r_ototal;
    assign o_none_visible   = r_onone;
    assign o_run_end        = r_olast;

    // checks
    a_kept_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kept <= 7'(vctk_pkg::MAX_CAND))
        else $error("kept count beyond store depth");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_onone) |-> (r_oid == 16'd0 && r_oscore == 26'sd0 && r_olast))
        else $error("empty result carries data");

    a_set_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_out_ready && r_olast) |=> (r_kept == 7'd0 && r_rej == 16'd0))
        else $error("set not cleared after last result");

endmodule

// ===== src/view_cone_cull_and_top_k_select_core.sv =====
`timescale 1ns / 1ps
// Candidates are taken one at a time; the next is taken once the previous one has finished.
// At a set end, no new candidate is taken until every emitted word (or the empty marker) is accepted.
// Reset: synchronous, active low; config returns to defaults, counts clear, store is not
//   cleared (only entries below the kept count are ever used).
// ============================================================================
// view_cone_cull_and_top_k_select_core
// Culls candidates against a view cone and near/far limits, keeps the best
// ones sorted by score, and emits them when a set ends.
// ============================================================================
module view_cone_cull_and_top_k_select_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data,
    vctk_cand_if.sink   i_cand,
    vctk_res_if.source  o_res
);

    vctk_pkg::t_cmd  w_cmd;
    vctk_pkg::t_stat w_stat;
    logic            w_in_ready;

    assign i_cand.ready = w_in_ready;

    // sequencer: one state per phase, iteration counts come back as status
    vctk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cand.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // datapath: the store is a 64 x 44 memory with one read and one write port, kept in
    // descending score order; inserts shift entries one per cycle from the tail
    vctk_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_obj_x          (i_cand.obj_x),
        .i_obj_y          (i_cand.obj_y),
        .i_obj_z          (i_cand.obj_z),
        .i_bound_radius   (i_cand.bound_radius),
        .i_importance     (i_cand.importance),
        .i_coverage       (i_cand.coverage),
        .i_full_detail    (i_cand.full_detail),
        .i_object_id      (i_cand.object_id),
        .i_set_end        (i_cand.set_end),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_out_ready      (o_res.ready),
        .o_out_valid      (o_res.valid),
        .o_out_id         (o_res.out_id),
        .o_detail_level   (o_res.detail_level),
        .o_rank_score     (o_res.rank_score),
        .o_rejected_total (o_res.rejected_total),
        .o_none_visible   (o_res.none_visible),
        .o_run_end        (o_res.run_end)
    );

endmodule

// ===== verif/view_cone_cull_and_top_k_select_core_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// view_cone_cull_and_top_k_select_core_tb
// Self-checking bench for the cull and top-k core. Candidates are sent on the
// input channel, and a local copy of the cull, score and sorted-store behavior
// predicts every result word. Results are checked field by field in order.
// Directed sets, config sweeps, a store overflow set, a long output stall and
// random sets are run in turn.
// ============================================================================
module view_cone_cull_and_top_k_select_core_tb;

    localparam int WDOG_LIMIT = 20000;
    localparam int HOLD_LEN   = 1500;
    localparam int SETTLE     = 200;

    typedef struct {
        logic signed [23:0] x, y, z;
        logic [23:0]        radius;
        logic [15:0]        imp, cov;
        logic               full_lod;
        logic [15:0]        id;
        logic               eos;
    } t_cand;

    typedef struct {
        logic [15:0] id;
        logic [1:0]  lvl;
        logic [25:0] score;
        logic [15:0] rej;
        logic        none;
        logic        last;
    } t_res;

    typedef struct {
        logic [15:0] id;
        logic [1:0]  lvl;
        longint      score;
    } t_kept;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                 i_cfg_we;
    vctk_pkg::t_cfg_idx   i_cfg_idx;
    logic [47:0]          i_cfg_data;

    vctk_cand_if cand ();
    vctk_res_if  res ();

    view_cone_cull_and_top_k_select_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cand     (cand.sink),
        .o_res      (res.source)
    );

    always #5 i_clk = ~i_clk;

    // local copy of the configuration
    longint      view_x, view_y, view_z;
    longint      fwd_x, fwd_y, fwd_z;
    longint      cone_lim;
    longint      near_d, far_d;
    int unsigned budget;

    t_kept       ranked_q[$];   // kept candidates, best score first
    int unsigned culled_cnt;
    t_res        pending_words[$];

    int unsigned n_items, n_words, n_sets, n_errors, n_mismatch;
    int unsigned hold_cycles;
    int unsigned rdy_stall;
    int unsigned idle_cnt;
    bit          quiet;

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'h4000_0000_0000_0000;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic int unsigned sat16(input int unsigned a);
        return (a > 65535) ? 65535 : a;
    endfunction

    task automatic reset_model();
        view_x = 0; view_y = 0; view_z = 0;
        fwd_x = 0; fwd_y = 0; fwd_z = 16384;
        cone_lim = 14189;
        near_d = 26;
        far_d = 24'hFFFFFF;
        budget = 64;
        ranked_q.delete();
        culled_cnt = 0;
    endtask

    // cull test, score, detail level and sorted insert for one candidate
    task automatic rank_candidate(input t_cand c);
        longint dx, dy, dz, rng, facing, score;
        longint unsigned sq;
        t_kept  e;
        int     p;
        dx = longint'(c.x) - view_x;
        dy = longint'(c.y) - view_y;
        dz = longint'(c.z) - view_z;
        sq = longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
        rng = longint'(int_sqrt(sq));
        if (rng < near_d || rng - longint'(c.radius) > far_d || rng == 0) begin
            culled_cnt = sat16(culled_cnt + 1);
            return;
        end
        facing = (dx * fwd_x + dy * fwd_y + dz * fwd_z) / rng;
        if (facing < cone_lim && !c.full_lod) begin
            culled_cnt = sat16(culled_cnt + 1);
            return;
        end
        score = longint'(c.imp) * 2 + longint'(c.cov) * 4 + (facing >>> 2)
                - (rng * 41) / 256;
        if (c.full_lod || c.cov > vctk_pkg::COV_FULL_TH || c.imp > vctk_pkg::IMP_FULL_TH)
            e.lvl = vctk_pkg::LVL_FULL;
        else if (c.cov > vctk_pkg::COV_MID_TH) e.lvl = vctk_pkg::LVL_MID;
        else e.lvl = vctk_pkg::LVL_COARSE;
        if (ranked_q.size() >= vctk_pkg::MAX_CAND) begin
            culled_cnt = sat16(culled_cnt + 1);
            return;
        end
        e.id = c.id;
        e.score = score;
        p = 0;
        while (p < ranked_q.size() && ranked_q[p].score >= score) p++;
        ranked_q.insert(p, e);
    endtask

    // at set end: queue the top words, or one empty marker
    task automatic close_set();
        int unsigned lim, cnt, total;
        t_res w;
        lim = (budget > 64) ? 64 : budget;
        cnt = (ranked_q.size() < lim) ? ranked_q.size() : lim;
        total = sat16(culled_cnt + ranked_q.size() - cnt);
        if (cnt == 0) begin
            w = '{id: '0, lvl: '0, score: '0, rej: total[15:0], none: 1'b1, last: 1'b1};
            pending_words.insert(pending_words.size(), w);
        end else begin
            for (int i = 0; i < cnt; i++) begin
                w.id = ranked_q[i].id;
                w.lvl = ranked_q[i].lvl;
                w.score = ranked_q[i].score[25:0];
                w.rej = total[15:0];
                w.none = 1'b0;
                w.last = (i + 1 == cnt);
                pending_words.insert(pending_words.size(), w);
            end
        end
        ranked_q.delete();
        culled_cnt = 0;
        n_sets++;
    endtask

    // must be called on a clock edge; leaves valid high after acceptance
    task automatic send_cand(input t_cand c);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            cand.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cand.valid        <= 1'b1;
        cand.obj_x        <= c.x;
        cand.obj_y        <= c.y;
        cand.obj_z        <= c.z;
        cand.bound_radius <= c.radius;
        cand.importance   <= c.imp;
        cand.coverage     <= c.cov;
        cand.full_detail  <= c.full_lod;
        cand.object_id    <= c.id;
        cand.set_end      <= c.eos;
        do @(posedge i_clk); while (!cand.ready);
        n_items++;
        rank_candidate(c);
        if (c.eos) close_set();
    endtask

    // drop valid, wait for every word, then let the core settle
    task automatic drain();
        cand.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input vctk_pkg::t_cfg_idx idx, input logic [47:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            vctk_pkg::CFG_VIEWER_X: view_x = longint'($signed(v[23:0]));
            vctk_pkg::CFG_VIEWER_Y: view_y = longint'($signed(v[23:0]));
            vctk_pkg::CFG_VIEWER_Z: view_z = longint'($signed(v[23:0]));
            vctk_pkg::CFG_VIEW_DIR: begin
                fwd_x = longint'($signed(v[15:0]));
                fwd_y = longint'($signed(v[31:16]));
                fwd_z = longint'($signed(v[47:32]));
            end
            vctk_pkg::CFG_CONE_COS: cone_lim = longint'($signed(v[15:0]));
            vctk_pkg::CFG_NEAR:     near_d = longint'(v[23:0]);
            vctk_pkg::CFG_FAR:      far_d = longint'(v[23:0]);
            vctk_pkg::CFG_BUDGET:   budget = 32'(v[6:0]);
            default: ;
        endcase
    endtask

    task automatic write_defaults();
        write_reg(vctk_pkg::CFG_VIEWER_X, 48'd0);
        write_reg(vctk_pkg::CFG_VIEWER_Y, 48'd0);
        write_reg(vctk_pkg::CFG_VIEWER_Z, 48'd0);
        write_reg(vctk_pkg::CFG_VIEW_DIR, 48'h4000_0000_0000);
        write_reg(vctk_pkg::CFG_CONE_COS, 48'd14189);
        write_reg(vctk_pkg::CFG_NEAR, 48'd26);
        write_reg(vctk_pkg::CFG_FAR, 48'hFF_FFFF);
        write_reg(vctk_pkg::CFG_BUDGET, 48'd64);
    endtask

    function automatic t_cand mk(input int x, input int y, input int z, input int r,
                                 input int imp, input int cov, input bit f,
                                 input int id, input bit e);
        t_cand c;
        c.x = x[23:0]; c.y = y[23:0]; c.z = z[23:0];
        c.radius = r[23:0];
        c.imp = imp[15:0]; c.cov = cov[15:0];
        c.full_lod = f;
        c.id = id[15:0];
        c.eos = e;
        return c;
    endfunction

    // mostly a candidate ahead of the viewer, sometimes raw bits
    function automatic t_cand rand_cand(input bit e);
        t_cand c;
        int    ox, oy, oz;
        if ($urandom_range(0, 4) == 0) begin
            c.x = 24'($urandom); c.y = 24'($urandom); c.z = 24'($urandom);
            c.radius = 24'($urandom);
            c.imp = 16'($urandom); c.cov = 16'($urandom);
        end else begin
            ox = $urandom_range(0, 40000) - 20000;
            oy = $urandom_range(0, 40000) - 20000;
            oz = $urandom_range(0, 3) == 0 ? $urandom_range(0, 2000)
                                            : $urandom_range(300, 300000);
            c.x = 24'(view_x + ox);
            c.y = 24'(view_y + oy);
            c.z = 24'(view_z + oz);
            c.radius = $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(0, 4096));
            c.imp = $urandom_range(0, 1) ? 16'($urandom_range(0, 5000)) : 16'($urandom);
            c.cov = $urandom_range(0, 1) ? 16'($urandom_range(0, 2000)) : 16'($urandom);
        end
        c.full_lod = ($urandom_range(0, 7) == 0);
        c.id = 16'($urandom);
        c.eos = e;
        return c;
    endfunction

    task automatic send_rand_set(input int len);
        for (int i = 0; i < len; i++) send_cand(rand_cand(i == len - 1));
    endtask

    // ---------------------------------------------------------------- tests
    // culling edges, detail thresholds, ties and field extremes at defaults
    task automatic test_directed();
        send_cand(mk(0, 0, 0, 0, 100, 100, 0, 1, 0));               // zero distance
        send_cand(mk(0, 0, 20, 0, 100, 100, 0, 2, 0));              // too near
        send_cand(mk(0, 0, 2560, 0, 65535, 65535, 0, 3, 0));
        send_cand(mk(0, 0, 2560, 0, 0, 0, 0, 4, 0));
        send_cand(mk(0, 0, 2560, 0, 0, 500, 0, 5, 0));
        send_cand(mk(0, 0, 2560, 0, 3276, 1433, 0, 6, 0));          // just under full
        send_cand(mk(0, 0, 2560, 0, 0, 1434, 0, 7, 0));
        send_cand(mk(0, 0, 2560, 0, 3277, 0, 0, 8, 0));
        send_cand(mk(0, 0, 2560, 0, 0, 327, 0, 9, 0));
        send_cand(mk(0, 0, 2560, 0, 0, 328, 0, 10, 0));
        send_cand(mk(2560, 0, 0, 0, 200, 200, 0, 11, 0));           // outside cone
        send_cand(mk(2560, 0, 0, 0, 200, 200, 1, 12, 0));           // forced through
        send_cand(mk(0, 0, -2560, 0, 200, 200, 1, 13, 0));          // behind viewer
        send_cand(mk(0, 100, 3000, 5, 700, 700, 0, 14, 0));         // equal scores
        send_cand(mk(0, 100, 3000, 5, 700, 700, 0, 15, 0));
        send_cand(mk(8388607, 8388607, 8388607, 0, 1, 1, 0, 16, 0));
        send_cand(mk(-8388608, -8388608, -8388608, 0, 1, 1, 1, 17, 0));
        send_cand(mk(0, 0, 8388607, 16777215, 9, 9, 0, 18, 0));
        send_cand(mk(0, 0, 512, 0, 0, 0, 0, 65535, 1));
        // a set with nothing kept
        send_cand(mk(0, 0, 0, 0, 0, 0, 0, 0, 1));
        drain();
    endtask

    // every register, including extreme values
    task automatic test_config_sweep();
        write_reg(vctk_pkg::CFG_VIEWER_X, 48'h80_0000);
        write_reg(vctk_pkg::CFG_VIEWER_Y, 48'h7F_FFFF);
        write_reg(vctk_pkg::CFG_VIEWER_Z, 48'h00_0000);
        write_reg(vctk_pkg::CFG_BUDGET, 48'd127);                   // acts as 64
        send_rand_set(8);
        drain();

        write_reg(vctk_pkg::CFG_VIEWER_X, 48'h00_1234);
        write_reg(vctk_pkg::CFG_VIEWER_Y, 48'hFF_F000);
        write_reg(vctk_pkg::CFG_VIEW_DIR, 48'h7FFF_7FFF_7FFF);      // far from unit length
        write_reg(vctk_pkg::CFG_CONE_COS, 48'hC000);                // -1.0
        write_reg(vctk_pkg::CFG_BUDGET, 48'd1);
        send_rand_set(8);
        drain();

        write_reg(vctk_pkg::CFG_VIEW_DIR, 48'h8000_8000_8000);
        write_reg(vctk_pkg::CFG_CONE_COS, 48'h4000);                // +1.0
        write_reg(vctk_pkg::CFG_NEAR, 48'd0);
        write_reg(vctk_pkg::CFG_FAR, 48'd0);
        write_reg(vctk_pkg::CFG_BUDGET, 48'd64);
        send_cand(mk(32'h1234, -4096, 0, 0, 5, 5, 1, 100, 0));     // distance zero, near 0
        send_cand(mk(32'h1234, -4096, 1000, 1000, 5, 5, 1, 101, 0)); // radius exactly reaches
        send_cand(mk(32'h1234, -4096, 1000, 999, 5, 5, 1, 102, 0));  // beyond far
        send_rand_set(6);
        drain();

        write_reg(vctk_pkg::CFG_NEAR, 48'hFF_FFFF);                 // everything too near
        write_reg(vctk_pkg::CFG_BUDGET, 48'd3);
        send_rand_set(5);
        drain();

        write_defaults();
        write_reg(vctk_pkg::CFG_BUDGET, 48'd0);                     // only the empty marker emitted
        send_rand_set(6);
        drain();
        write_reg(vctk_pkg::CFG_BUDGET, 48'd64);
    endtask

    // more kept candidates than the store holds, then over budget
    task automatic test_store_full();
        write_reg(vctk_pkg::CFG_NEAR, 48'd0);
        for (int k = 0; k < 70; k++)
            send_cand(mk(0, 0, 256 * (k + 1), 0, $urandom_range(0, 65535),
                         $urandom_range(0, 65535), 1, k, k == 69));
        drain();
        write_reg(vctk_pkg::CFG_BUDGET, 48'd5);
        for (int k = 0; k < 12; k++)
            send_cand(mk(0, 0, 256 * (k + 1), 0, 1000, 100 * k, 1, 200 + k, k == 11));
        drain();
        write_defaults();
    endtask

    // output held off for a long stretch while sets keep coming
    task automatic test_output_stall();
        hold_cycles = HOLD_LEN;
        send_rand_set(4);
        send_rand_set(6);
        send_rand_set(5);
        drain();
    endtask

    task automatic test_random();
        int sent;
        int len;
        sent = 0;
        while (sent < 115) begin
            len = $urandom_range(1, 16);
            quiet = ($urandom_range(0, 4) == 0);
            send_rand_set(len);
            sent += len;
            if ($urandom_range(0, 3) == 0) begin
                drain();
                write_reg(vctk_pkg::CFG_BUDGET, 48'($urandom_range(0, 70)));
                write_reg(vctk_pkg::CFG_CONE_COS, 48'($urandom_range(10000, 16384)));
            end
        end
        quiet = 1'b0;
        drain();
    endtask

    // ---------------------------------------------------------------- result side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res.ready <= 1'b0;
            rdy_stall = 0;
        end else if (hold_cycles > 0) begin
            res.ready <= 1'b0;
            hold_cycles--;
        end else if (rdy_stall > 0) begin
            res.ready <= 1'b0;
            rdy_stall--;
        end else if (res.valid && res.ready && !quiet) begin
            rdy_stall = $urandom_range(0, 3);
            if (rdy_stall > 0) begin
                res.ready <= 1'b0;
                rdy_stall--;
            end else begin
                res.ready <= 1'b1;
            end
        end else begin
            res.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_res w;
        if (i_rst_n && res.valid && res.ready) begin
            n_words++;
            if (pending_words.size() == 0) begin
                n_errors++;
                if (n_mismatch < 10)
                    $display("%0t: unexpected word id=%0d", $time, res.out_id);
                n_mismatch++;
            end else begin
                w = pending_words.pop_front();
                if (res.out_id !== w.id || res.detail_level !== w.lvl ||
                    res.rank_score !== w.score || res.rejected_total !== w.rej ||
                    res.none_visible !== w.none || res.run_end !== w.last) begin
                    n_errors++;
                    if (n_mismatch < 10) begin
                        $display("%0t: mismatch exp id=%0d lvl=%0d score=%0h rej=%0d none=%b end=%b",
                                 $time, w.id, w.lvl, w.score, w.rej, w.none, w.last);
                        $display("    got id=%0d lvl=%0d score=%0h rej=%0d none=%b end=%b",
                                 res.out_id, res.detail_level, res.rank_score,
                                 res.rejected_total, res.none_visible, res.run_end);
                    end
                    n_mismatch++;
                end
            end
        end
    end

    // watchdog: cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if ((cand.valid && cand.ready) || (res.valid && res.ready)) idle_cnt = 0;
        else idle_cnt++;
        if (idle_cnt >= WDOG_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cnt);
            $display("view_cone_cull_and_top_k_select_core_tb: done, errors");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = vctk_pkg::CFG_VIEWER_X;
        i_cfg_data = '0;
        cand.valid = 1'b0;
        cand.obj_x = '0; cand.obj_y = '0; cand.obj_z = '0;
        cand.bound_radius = '0;
        cand.importance = '0; cand.coverage = '0;
        cand.full_detail = 1'b0;
        cand.object_id = '0;
        cand.set_end = 1'b0;
        res.ready = 1'b0;
        n_items = 0; n_words = 0; n_sets = 0; n_errors = 0; n_mismatch = 0;
        hold_cycles = 0; idle_cnt = 0; quiet = 1'b0;
        reset_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_config_sweep();
        test_store_full();
        test_output_stall();
        test_random();

        if (pending_words.size() != 0) begin
            n_errors++;
            $display("%0d expected words never arrived", pending_words.size());
        end
        $display("covered %0d candidates in %0d sets, %0d result words checked",
                 n_items, n_sets, n_words);
        $display("config sweep, store overflow, budget limits and a %0d cycle output stall",
                 HOLD_LEN);
        if (n_errors == 0)
            $display("view_cone_cull_and_top_k_select_core_tb: done, clean");
        else
            $display("view_cone_cull_and_top_k_select_core_tb: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/vctk_pkg.sv
src/vctk_cand_if.sv
src/vctk_res_if.sv
src/vctk_ctrl.sv
src/vctk_dp.sv
src/view_cone_cull_and_top_k_select_core.sv
verif/view_cone_cull_and_top_k_select_core_tb.sv
